>>> rtl/cop_pkg.sv
// ============================================================================
// cop_pkg: shared types, constants and arithmetic helpers
// Fixed-point formats, the CORDIC angle table and the Q30 product helpers
// used by the orbit state generator.
// ============================================================================
package cop_pkg;

    // CORDIC precision and widths
    localparam int TRIG_FRAC_BITS = 24;
    localparam int CORDIC_STAGES  = TRIG_FRAC_BITS;
    localparam int CORDIC_W       = TRIG_FRAC_BITS + 3;
    localparam int ANGLE_W        = 33;
    localparam int Q30_LSH        = (TRIG_FRAC_BITS < 30) ? 30 - TRIG_FRAC_BITS : 0;
    localparam int Q30_RSH        = (TRIG_FRAC_BITS >= 30) ? TRIG_FRAC_BITS - 30 : 0;

    // Datapath widths
    localparam int TIME_W   = 32;
    localparam int RAD_W    = 24;
    localparam int RATE_W   = 32;
    localparam int TRIG_W   = 32;
    localparam int BIG_W    = 40;
    localparam int OUT_W    = 48;
    localparam int N_OUT    = 9;
    localparam int PROD_W   = RAD_W + BIG_W + 1;
    localparam int Q30_SHIFT = 30;
    localparam int OUT_SHIFT = 14;
    localparam int RATE_SHIFT = 31;

    // Register map
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [31:0] GAIN_Q32   = 32'd2608131496;
    localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
    localparam logic signed [CORDIC_W-1:0] CORDIC_X0 =
        CORDIC_W'(GAIN_Q32 >> (32 - TRIG_FRAC_BITS));

    // Arctangent of 2^-i in Q0.32 turns
    localparam logic [31:0] ATAN_TURNS [0:31] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef enum logic [1:0] {
        REG_SAT_RATE   = 2'd0,
        REG_EARTH_RATE = 2'd1,
        REG_INCL_PHASE = 2'd2
    } t_reg_idx;

    typedef logic signed [TRIG_W-1:0] t_trig;
    typedef logic signed [BIG_W-1:0]  t_big;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic [OUT_W-1:0]         t_word;
    typedef t_word [N_OUT-1:0]        t_state;

    // Configuration-derived terms, all Q30
    typedef struct packed {
        t_trig ci;
        t_trig si;
        t_big  cv1;
        t_big  cv2;
        t_big  ca1;
        t_big  ca2;
        t_big  wsi;
        t_big  wwsi;
    } t_consts;

    localparam t_prod SAT_HI = t_prod'($signed({1'b0, {(OUT_W-1){1'b1}}}));
    localparam t_prod SAT_LO = -SAT_HI - t_prod'(1);

    // floor(a*b / 2^30) for two trig values
    function automatic t_trig mul_tt(t_trig a, t_trig b);
        logic signed [2*TRIG_W-1:0] p;
        p = (2*TRIG_W)'(a) * (2*TRIG_W)'(b);
        return t_trig'(p >>> Q30_SHIFT);
    endfunction

    // floor(a*b / 2^30) for a trig value and a wide term
    function automatic t_big mul_tb(t_trig a, t_big b);
        logic signed [TRIG_W+BIG_W-1:0] p;
        p = (TRIG_W+BIG_W)'(a) * (TRIG_W+BIG_W)'(b);
        return t_big'(p >>> Q30_SHIFT);
    endfunction

    // floor(a*b / 2^30) for two wide terms
    function automatic t_big mul_bb(t_big a, t_big b);
        logic signed [2*BIG_W-1:0] p;
        p = (2*BIG_W)'(a) * (2*BIG_W)'(b);
        return t_big'(p >>> Q30_SHIFT);
    endfunction

    // Scale down to Q31.16 and clamp to the signed 48-bit range
    function automatic t_word sat_out(t_prod p);
        t_prod s;
        s = p >>> OUT_SHIFT;
        if (s > SAT_HI) begin
            return SAT_HI[OUT_W-1:0];
        end else if (s < SAT_LO) begin
            return SAT_LO[OUT_W-1:0];
        end
        return s[OUT_W-1:0];
    endfunction

endpackage

>>> rtl/cop_cordic.sv
// ============================================================================
// cop_cordic: pipelined sine/cosine unit
// One rotation per stage over the low 30 phase bits, then clamp, scale to
// Q30 and fold in the quadrant. One phase in per enabled cycle.
// ============================================================================
module cop_cordic
    import cop_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_phase,
    output t_trig       o_cos,
    output t_trig       o_sin
);

    logic signed [CORDIC_W-1:0] r_x [1:CORDIC_STAGES];
    logic signed [CORDIC_W-1:0] r_y [1:CORDIC_STAGES];
    logic signed [ANGLE_W-1:0]  r_z [1:CORDIC_STAGES];
    logic [1:0]                 r_q [1:CORDIC_STAGES];

    logic signed [CORDIC_W-1:0] c_x [0:CORDIC_STAGES-1];
    logic signed [CORDIC_W-1:0] c_y [0:CORDIC_STAGES-1];
    logic signed [ANGLE_W-1:0]  c_z [0:CORDIC_STAGES-1];
    logic [1:0]                 c_q [0:CORDIC_STAGES-1];

    logic signed [CORDIC_W-1:0]         x_cl;
    logic signed [CORDIC_W-1:0]         y_cl;
    logic signed [CORDIC_W+Q30_LSH-1:0] x_sc;
    logic signed [CORDIC_W+Q30_LSH-1:0] y_sc;
    t_trig                              x_q30;
    t_trig                              y_q30;
    t_trig                              n_cos;
    t_trig                              n_sin;
    t_trig                              r_cos;
    t_trig                              r_sin;

    localparam logic signed [CORDIC_W-1:0] ONE = CORDIC_W'(1) <<< TRIG_FRAC_BITS;

    // Stage inputs: the fresh phase, then each stage's register
    always_comb begin
        c_x[0] = CORDIC_X0;
        c_y[0] = '0;
        c_z[0] = ANGLE_W'({1'b0, i_phase[29:0]});
        c_q[0] = i_phase[31:30];
        for (int k = 1; k < CORDIC_STAGES; k++) begin
            c_x[k] = r_x[k];
            c_y[k] = r_y[k];
            c_z[k] = r_z[k];
            c_q[k] = r_q[k];
        end
    end

    // Rotate one step per stage toward zero residual angle
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < CORDIC_STAGES; i++) begin
                if (!c_z[i][ANGLE_W-1]) begin
                    r_x[i+1] <= c_x[i] - (c_y[i] >>> i);
                    r_y[i+1] <= c_y[i] + (c_x[i] >>> i);
                    r_z[i+1] <= c_z[i] - $signed({1'b0, ATAN_TURNS[i]});
                end else begin
                    r_x[i+1] <= c_x[i] + (c_y[i] >>> i);
                    r_y[i+1] <= c_y[i] - (c_x[i] >>> i);
                    r_z[i+1] <= c_z[i] + $signed({1'b0, ATAN_TURNS[i]});
                end
                r_q[i+1] <= c_q[i];
            end
        end
    end

    // Clamp to +-1.0, scale to Q30, apply the quadrant
    always_comb begin
        x_cl = r_x[CORDIC_STAGES];
        y_cl = r_y[CORDIC_STAGES];
        if (x_cl > ONE)  x_cl = ONE;
        if (x_cl < -ONE) x_cl = -ONE;
        if (y_cl > ONE)  y_cl = ONE;
        if (y_cl < -ONE) y_cl = -ONE;
        x_sc  = ((CORDIC_W+Q30_LSH)'(x_cl) <<< Q30_LSH) >>> Q30_RSH;
        y_sc  = ((CORDIC_W+Q30_LSH)'(y_cl) <<< Q30_LSH) >>> Q30_RSH;
        x_q30 = t_trig'(x_sc);
        y_q30 = t_trig'(y_sc);
        case (r_q[CORDIC_STAGES])
            2'd0: begin
                n_cos = x_q30;
                n_sin = y_q30;
            end
            2'd1: begin
                n_cos = -y_q30;
                n_sin = x_q30;
            end
            2'd2: begin
                n_cos = -x_q30;
                n_sin = -y_q30;
            end
            default: begin
                n_cos = y_q30;
                n_sin = -x_q30;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= n_cos;
            r_sin <= n_sin;
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

>>> rtl/cop_consts.sv
// ============================================================================
// cop_consts: configuration-derived terms
// Free-running pipeline from the rate and inclination registers to the
// Q30 velocity and acceleration coefficients used per item.
// ============================================================================
module cop_consts
    import cop_pkg::*;
(
    input  logic              i_clk,
    input  logic [RATE_W-1:0] i_sat_rate,
    input  logic [RATE_W-1:0] i_earth_rate,
    input  logic [31:0]       i_incl_phase,
    output t_consts           o_k
);

    t_big    r_w;
    t_big    r_e;
    t_big    r_w2;
    t_big    r_e2;
    t_big    r_ww;
    t_big    r_ee;
    t_big    r_mwe;
    t_big    r_w3;
    t_big    r_e3;
    t_big    r_ww3;
    t_big    r_sq;
    t_big    r_we2;
    t_trig   ci;
    t_trig   si;
    t_consts r_k;

    // Rate in turns times 2*pi, rounded to Q30
    function automatic t_big rate_q30(logic [RATE_W-1:0] rate);
        logic [63:0] p;
        p = 64'(rate) * 64'(TWO_PI_Q29) + (64'(1) << Q30_SHIFT);
        return t_big'(p >> RATE_SHIFT);
    endfunction

    // Inclination sine and cosine
    cop_cordic u_incl (
        .i_clk   (i_clk),
        .i_en    (1'b1),
        .i_phase (i_incl_phase),
        .o_cos   (ci),
        .o_sin   (si)
    );

    // Rates, their squares and sums
    always_ff @(posedge i_clk) begin
        r_w   <= rate_q30(i_sat_rate);
        r_e   <= rate_q30(i_earth_rate);
        r_ww  <= mul_bb(r_w, r_w);
        r_ee  <= mul_bb(r_e, r_e);
        r_mwe <= mul_bb(r_w, r_e);
        r_w2  <= r_w;
        r_e2  <= r_e;
        r_sq  <= r_ww + r_ee;
        r_we2 <= r_mwe <<< 1;
        r_ww3 <= r_ww;
        r_w3  <= r_w2;
        r_e3  <= r_e2;
    end

    // Combine with the inclination terms
    always_ff @(posedge i_clk) begin
        r_k.ci   <= ci;
        r_k.si   <= si;
        r_k.cv1  <= mul_tb(ci, r_e3) - r_w3;
        r_k.cv2  <= mul_tb(ci, r_w3) - r_e3;
        r_k.ca1  <= mul_tb(ci, r_we2) - r_sq;
        r_k.ca2  <= r_we2 - mul_tb(ci, r_sq);
        r_k.wsi  <= mul_tb(si, r_w3);
        r_k.wwsi <= mul_tb(si, r_ww3);
    end

    assign o_k = r_k;

endmodule

>>> rtl/cop_kinematics.sv
// ============================================================================
// cop_kinematics: product, sum and scaling stages
// Forms the frame products, the nine Q30 sums, scales by the radius and
// saturates to Q31.16 over five register stages.
// ============================================================================
module cop_kinematics
    import cop_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_trig            i_cs,
    input  t_trig            i_ss,
    input  t_trig            i_ce,
    input  t_trig            i_se,
    input  logic [RAD_W-1:0] i_rad,
    input  t_consts          i_k,
    output logic             o_valid,
    output t_state           o_state
);

    logic [4:0] r_vld;

    // Stage A
    t_trig            r_a_pcc, r_a_pss, r_a_pcs, r_a_psc, r_a_pz;
    t_big             r_a_vz, r_a_az;
    logic [RAD_W-1:0] r_a_rad;
    // Stage B
    t_trig            r_b_pcc, r_b_pcs, r_b_m0, r_b_m1, r_b_pz;
    t_big             r_b_v0, r_b_v1, r_b_v2, r_b_v3;
    t_big             r_b_a0, r_b_a1, r_b_a2, r_b_a3, r_b_vz, r_b_az;
    logic [RAD_W-1:0] r_b_rad;
    // Stage C
    t_big             r_c_p [N_OUT];
    logic [RAD_W-1:0] r_c_rad;
    // Stage D
    t_prod            r_d_prod [N_OUT];
    // Stage E
    t_state           r_e_state;

    // Advance valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    // Frame products and the z terms
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_pcc <= mul_tt(i_cs, i_ce);
            r_a_pss <= mul_tt(i_ss, i_se);
            r_a_pcs <= mul_tt(i_cs, i_se);
            r_a_psc <= mul_tt(i_ss, i_ce);
            r_a_pz  <= mul_tt(i_k.si, i_ss);
            r_a_vz  <= mul_tb(i_cs, i_k.wsi);
            r_a_az  <= -mul_tb(i_ss, i_k.wwsi);
            r_a_rad <= i_rad;
        end
    end

    // Coefficient products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_pcc <= r_a_pcc;
            r_b_pcs <= r_a_pcs;
            r_b_m0  <= mul_tt(i_k.ci, r_a_pss);
            r_b_m1  <= mul_tt(i_k.ci, r_a_psc);
            r_b_pz  <= r_a_pz;
            r_b_v0  <= mul_tb(r_a_psc, i_k.cv1);
            r_b_v1  <= mul_tb(r_a_pcs, i_k.cv2);
            r_b_v2  <= mul_tb(r_a_pss, -i_k.cv1);
            r_b_v3  <= mul_tb(r_a_pcc, i_k.cv2);
            r_b_a0  <= mul_tb(r_a_pcc, i_k.ca1);
            r_b_a1  <= mul_tb(r_a_pss, i_k.ca2);
            r_b_a2  <= mul_tb(r_a_pcs, -i_k.ca1);
            r_b_a3  <= mul_tb(r_a_psc, i_k.ca2);
            r_b_vz  <= r_a_vz;
            r_b_az  <= r_a_az;
            r_b_rad <= r_a_rad;
        end
    end

    // Nine Q30 sums
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_p[0] <= t_big'(r_b_pcc) + t_big'(r_b_m0);
            r_c_p[1] <= t_big'(r_b_m1) - t_big'(r_b_pcs);
            r_c_p[2] <= t_big'(r_b_pz);
            r_c_p[3] <= r_b_v0 + r_b_v1;
            r_c_p[4] <= r_b_v2 + r_b_v3;
            r_c_p[5] <= r_b_vz;
            r_c_p[6] <= r_b_a0 + r_b_a1;
            r_c_p[7] <= r_b_a2 + r_b_a3;
            r_c_p[8] <= r_b_az;
            r_c_rad  <= r_b_rad;
        end
    end

    // Scale by radius, then saturate
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < N_OUT; j++) begin
                r_d_prod[j] <= t_prod'($signed({1'b0, r_c_rad})) * t_prod'(r_c_p[j]);
                r_e_state[j] <= sat_out(r_d_prod[j]);
            end
        end
    end

    assign o_valid = r_vld[4];
    assign o_state = r_e_state;

endmodule

>>> rtl/cop_out_buf.sv
// ============================================================================
// cop_out_buf: output register with skid stage
// Holds a finished result for the consumer and catches one more while the
// pipeline is told to hold.
// ============================================================================
module cop_out_buf
    import cop_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_state i_data,
    input  logic   i_ready,
    output logic   o_valid,
    output t_state o_data,
    output logic   o_full
);

    logic   r_main_valid;
    logic   r_skid_valid;
    t_state r_main;
    t_state r_skid;
    logic   pop;

    assign pop = r_main_valid && i_ready;

    // Control: main register first, skid behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (r_main_valid && !pop) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_main_valid <= 1'b1;
            end
        end else if (pop) begin
            r_main_valid <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_main <= r_skid;
            end
        end else if (i_push) begin
            if (r_main_valid && !pop) begin
                r_skid <= i_data;
            end else begin
                r_main <= i_data;
            end
        end
    end

    assign o_valid = r_main_valid;
    assign o_data  = r_main;
    assign o_full  = r_skid_valid;

    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid holds a result while main is empty");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_push)
        else $error("result pushed while skid is full");

    a_stall_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && r_main_valid && !i_ready) |=> r_skid_valid)
        else $error("stalled result not caught in skid");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_ready) |=> (r_main_valid && !r_skid_valid))
        else $error("skid did not move to main on transfer");

endmodule

>>> rtl/circular_orbit_state_generator.sv
// ============================================================================
// circular_orbit_state_generator: inclined circular orbit state in an
// Earth-fixed rotating frame
// Takes (time, radius) items and returns position, velocity and
// acceleration as nine saturating Q31.16 values.
// ============================================================================
// The block accepts one item per clock and returns one result per item, in
// order. Each item passes through the phase product register, the
// pipelined CORDIC, five product, sum and scale stages, and the output
// register. Throughput is set by the one-rotation-per-stage CORDIC pipeline
// and holds at one item per cycle while m_axis_tready stays high; a
// one-entry skid lets the output stall without losing an item. Register
// writes apply to items accepted after the write.
module circular_orbit_state_generator
    import cop_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // Input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [55:0]           s_axis_tdata,  // time_ticks[31:0], orbit_radius[55:32]
    // Output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [431:0]          m_axis_tdata   // pos_x, pos_y, pos_z, vel_x, vel_y,
                                                 // vel_z, acc_x, acc_y, acc_z; 48 b each
);

    localparam int FRONT = CORDIC_STAGES + 2;

    logic [RATE_W-1:0] r_sat_rate;
    logic [RATE_W-1:0] r_earth_rate;
    logic [31:0]       r_incl_phase;

    logic             en;
    logic             full;
    logic [31:0]      r_ph_s;
    logic [31:0]      r_ph_e;
    logic             r_vld [0:FRONT-1];
    logic [RAD_W-1:0] r_rad [0:FRONT-1];

    t_trig   cs, ss, ce, se;
    t_consts k;
    logic    kin_valid;
    t_state  kin_state;

    logic              wr_en;
    logic [1:0]        reg_idx;
    logic [TIME_W-1:0] in_time;
    logic [RAD_W-1:0]  in_rad;

    assign in_time = s_axis_tdata[TIME_W-1:0];
    assign in_rad  = s_axis_tdata[TIME_W+RAD_W-1:TIME_W];

    // Register writes
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat_rate   <= '0;
            r_earth_rate <= '0;
            r_incl_phase <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SAT_RATE:   r_sat_rate   <= pwdata;
                REG_EARTH_RATE: r_earth_rate <= pwdata;
                REG_INCL_PHASE: r_incl_phase <= pwdata;
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (reg_idx)
            REG_SAT_RATE:   prdata = r_sat_rate;
            REG_EARTH_RATE: prdata = r_earth_rate;
            REG_INCL_PHASE: prdata = r_incl_phase;
            default:        prdata = '0;
        endcase
    end

    // Hold the whole pipeline only while the skid is occupied
    assign en            = !full;
    assign s_axis_tready = en;

    // Phases: low 32 bits of rate times time
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ph_s <= 32'(64'(r_sat_rate) * 64'(in_time));
            r_ph_e <= 32'(64'(r_earth_rate) * 64'(in_time));
        end
    end

    // Valid bits and radius alongside the CORDIC
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < FRONT; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= s_axis_tvalid;
            for (int i = 1; i < FRONT; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rad[0] <= in_rad;
            for (int i = 1; i < FRONT; i++) begin
                r_rad[i] <= r_rad[i-1];
            end
        end
    end

    cop_cordic u_sat (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_phase (r_ph_s),
        .o_cos   (cs),
        .o_sin   (ss)
    );

    cop_cordic u_earth (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_phase (r_ph_e),
        .o_cos   (ce),
        .o_sin   (se)
    );

    cop_consts u_consts (
        .i_clk        (i_clk),
        .i_sat_rate   (r_sat_rate),
        .i_earth_rate (r_earth_rate),
        .i_incl_phase (r_incl_phase),
        .o_k          (k)
    );

    cop_kinematics u_kin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_vld[FRONT-1]),
        .i_cs    (cs),
        .i_ss    (ss),
        .i_ce    (ce),
        .i_se    (se),
        .i_rad   (r_rad[FRONT-1]),
        .i_k     (k),
        .o_valid (kin_valid),
        .o_state (kin_state)
    );

    cop_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (kin_valid && en),
        .i_data  (kin_state),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  (m_axis_tdata),
        .o_full  (full)
    );

endmodule
